FILE: sv/fcmt_pkg.sv
// shared types, constants and arithmetic helpers for the face momentum forcing block
`default_nettype none
package fcmt_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned DivSteps      = 33;

  localparam logic [63:0]        TermLim  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] TermLimW = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic [32:0]        Recip10  = 33'd6871947674;
  localparam int unsigned        Recip10Shift = 36;

  localparam logic signed [35:0] Int32MaxW = 36'sd2147483647;
  localparam logic signed [35:0] Int32MinW = -36'sd2147483648;
  localparam logic [31:0]        Int32Max  = 32'h7FFF_FFFF;
  localparam logic [31:0]        Int32Min  = 32'h8000_0000;

  // mode_flags bit positions
  localparam int unsigned ModeWind      = 0;
  localparam int unsigned ModeBody      = 1;
  localparam int unsigned ModeFeedback  = 2;
  localparam int unsigned ModeOceanDrag = 3;
  localparam int unsigned ModeRigidLid  = 4;

  typedef enum logic [2:0] {
    RegModeFlags       = 3'd0,
    RegLinDragBottom   = 3'd1,
    RegQuadDragBottom  = 3'd2,
    RegLinDragSurface  = 3'd3,
    RegQuadDragSurface = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic [31:0] lin_b;
    logic [31:0] quad_b;
    logic [31:0] lin_s;
    logic [31:0] quad_s;
  } cfg_t;

  // one entry of the queue between front and back
  typedef struct packed {
    logic signed [63:0] acc;
    logic signed [31:0] h;
    logic signed [31:0] fb;
    logic               hnz;
    logic               sat;
  } qent_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } acc_t;

  typedef struct packed {
    logic        sat;
    logic [61:0] mag;
  } mag_t;

  function automatic acc_t add_clamp(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    acc_t r;
    s = 65'(a) + 65'(b);
    r.sat = 1'b0;
    r.val = 64'(s);
    if (s > TermLimW) begin
      r.sat = 1'b1;
      r.val = 64'(TermLimW);
    end else if (s < -TermLimW) begin
      r.sat = 1'b1;
      r.val = 64'(-TermLimW);
    end
    return r;
  endfunction

  // q0.32 scaling from the two partial products
  function automatic mag_t scale32(input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] r;
    mag_t m;
    r = hi + {32'b0, lo[63:32]};
    m.sat = 1'b0;
    if (r > TermLim) begin
      m.sat = 1'b1;
      r = TermLim;
    end
    m.mag = r[61:0];
    return m;
  endfunction

  // q16.16 scaling from the two partial products
  function automatic mag_t scale16(input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] r;
    mag_t m;
    m.sat = 1'b0;
    if (hi > (TermLim >> 16)) begin
      m.sat = 1'b1;
      r = TermLim;
    end else begin
      r = (hi << 16) + {16'b0, lo[63:16]};
      if (r > TermLim) begin
        m.sat = 1'b1;
        r = TermLim;
      end
    end
    m.mag = r[61:0];
    return m;
  endfunction

  function automatic logic [62:0] abs64(input logic signed [63:0] x);
    logic signed [63:0] n;
    n = -x;
    return x[63] ? n[62:0] : x[62:0];
  endfunction

  // amount added to the sum for a drag term of given sign and magnitude (the negated term)
  function automatic logic signed [63:0] drag_delta(input logic neg, input logic [61:0] mag);
    logic signed [63:0] p;
    p = $signed({2'b00, mag});
    return neg ? p : -p;
  endfunction

  // floor(7*r/10) for a remainder digit
  function automatic logic [2:0] seven_tenths(input logic [3:0] r);
    logic [2:0] t;
    case (r)
      4'd0, 4'd1: t = 3'd0;
      4'd2:       t = 3'd1;
      4'd3, 4'd4: t = 3'd2;
      4'd5:       t = 3'd3;
      4'd6, 4'd7: t = 3'd4;
      4'd8:       t = 3'd5;
      4'd9:       t = 3'd6;
      default:    t = 3'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: sv/fcmt_queue.sv
// small fifo between the term pipeline and the divider
`default_nettype none
module fcmt_queue #(
  parameter int unsigned Depth = fcmt_pkg::QueueDepthDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fcmt_pkg::qent_t  push_data,
  output logic             full,
  input  logic             pop,
  output fcmt_pkg::qent_t  pop_data,
  output logic             empty
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fcmt_pkg::qent_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: sv/fcmt_front.sv
// front pipeline: accepts items and builds the clamped forcing sum
`default_nettype none
module fcmt_front (
  input  logic               clk,
  input  logic               rst,
  input  fcmt_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] face_velocity,
  input  logic signed [31:0] face_thickness,
  input  logic signed [31:0] surface_part,
  input  logic signed [31:0] bottom_part,
  input  logic signed [31:0] wind_stress,
  input  logic signed [31:0] lid_velocity,
  input  logic signed [31:0] body_force,
  input  logic [30:0]        bottom_speed_here,
  input  logic [30:0]        bottom_speed_behind,
  input  logic [30:0]        surface_speed_here,
  input  logic [30:0]        surface_speed_behind,
  input  logic               over_land,
  output logic               push,
  input  logic               q_full,
  output fcmt_pkg::qent_t    push_data
);
  localparam int unsigned Stages = 11;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] h;
    logic signed [31:0] sf;
    logic signed [31:0] lid;
    logic signed [31:0] fb;
    logic signed [31:0] bp;
    logic signed [31:0] tau;
    logic [30:0]        bspd;
    logic [30:0]        sspd;
    logic               wind;
    logic               fdbk;
    logic               mask;
    logic               hnz;
    logic               sat;
    logic signed [63:0] pub;
    logic signed [63:0] pw;
    logic signed [63:0] psl;
    logic signed [63:0] psq;
    logic signed [33:0] dl;
    logic signed [33:0] vfd;
    logic               uneg;
    logic [31:0]        umag;
    logic [27:0]        q1;
    logic [62:0]        pubm;
    logic [62:0]        pslm;
    logic [62:0]        psqm;
    logic               pubneg;
    logic               pslneg;
    logic               psqneg;
    logic signed [63:0] w;
    logic [63:0]        lbh;
    logic [63:0]        lbl;
    logic [63:0]        qbh;
    logic [63:0]        qbl;
    logic [63:0]        slh;
    logic [63:0]        sll;
    logic [63:0]        sqh;
    logic [63:0]        sql;
    logic [63:0]        m5h;
    logic [63:0]        m5l;
    logic [63:0]        sqmh;
    logic [63:0]        sqml;
    logic [61:0]        lb;
    logic [61:0]        qb1;
    logic [61:0]        qb;
    logic [61:0]        sl;
    logic [61:0]        sq1;
    logic [61:0]        sq;
    logic signed [63:0] acc;
  } fr_t;

  fr_t st [Stages];
  fr_t nx [Stages];
  logic [Stages-1:0] v;
  logic adv;

  assign adv      = !v[Stages-1] || !q_full;
  assign in_ready = adv;
  assign push     = v[Stages-1] && !q_full;

  always_comb begin
    push_data.acc = st[Stages-1].hnz ? st[Stages-1].acc : '0;
    push_data.h   = st[Stages-1].h;
    push_data.fb  = st[Stages-1].fb;
    push_data.hnz = st[Stages-1].hnz;
    push_data.sat = st[Stages-1].hnz && st[Stages-1].sat;
  end

  always_comb begin
    logic [31:0]        sum_b;
    logic [31:0]        sum_s;
    logic signed [31:0] nu;
    logic [63:0]        qprod;
    logic [31:0]        q1x;
    logic [31:0]        rem;
    logic [31:0]        vmag;
    logic signed [33:0] vpos;
    logic signed [33:0] vf;
    logic signed [65:0] pl;
    logic signed [65:0] pq;
    fcmt_pkg::acc_t     a;
    fcmt_pkg::mag_t     m;
    fcmt_pkg::mag_t     m2;

    // stage 0: register the item, decode mode
    nx[0]      = '0;
    sum_b      = 32'(bottom_speed_here) + 32'(bottom_speed_behind);
    sum_s      = 32'(surface_speed_here) + 32'(surface_speed_behind);
    nx[0].u    = face_velocity;
    nx[0].h    = face_thickness;
    nx[0].sf   = surface_part;
    nx[0].lid  = lid_velocity;
    nx[0].bp   = bottom_part;
    nx[0].tau  = wind_stress;
    nx[0].fb   = cfg.mode[fcmt_pkg::ModeBody] ? body_force : '0;
    nx[0].bspd = sum_b[31:1];
    nx[0].sspd = sum_s[31:1];
    nx[0].wind = cfg.mode[fcmt_pkg::ModeWind];
    nx[0].fdbk = cfg.mode[fcmt_pkg::ModeFeedback];
    nx[0].mask = !cfg.mode[fcmt_pkg::ModeOceanDrag] && cfg.mode[fcmt_pkg::ModeRigidLid]
                 && over_land;
    nx[0].hnz  = (face_thickness != '0);

    // stage 1: raw products, velocity / 10 by reciprocal
    nx[1]      = st[0];
    nx[1].pub  = 64'(st[0].u) * 64'(st[0].bp);
    nx[1].pw   = 64'(st[0].tau) * 64'(st[0].sf);
    nx[1].dl   = 34'(st[0].u) - 34'(st[0].lid);
    nx[1].uneg = st[0].u[31];
    nu         = -st[0].u;
    nx[1].umag = st[0].u[31] ? nu : st[0].u;
    qprod      = 64'(nx[1].umag) * 64'(fcmt_pkg::Recip10);
    nx[1].q1   = qprod[fcmt_pkg::Recip10Shift +: 28];

    // stage 2: feedback velocity, linear surface product, wind term
    nx[2]      = st[1];
    q1x        = 32'(st[1].q1);
    rem        = st[1].umag - ((q1x << 3) + (q1x << 1));
    vmag       = (q1x << 3) - q1x + 32'(fcmt_pkg::seven_tenths(rem[3:0]));
    vpos       = $signed({2'b00, vmag});
    vf         = st[1].fdbk ? (st[1].uneg ? -vpos : vpos) : 34'(st[1].u);
    nx[2].vfd  = vf - 34'(st[1].lid);
    pl         = 66'(st[1].dl) * 66'(st[1].sf);
    nx[2].psl  = pl[63:0];
    nx[2].pubm = fcmt_pkg::abs64(st[1].pub);
    nx[2].pubneg = st[1].pub[63];
    a          = fcmt_pkg::add_clamp(st[1].pw, '0);
    nx[2].w    = st[1].wind ? a.val : '0;
    nx[2].sat  = st[1].sat || (st[1].wind && a.sat);

    // stage 3: bottom partial products, quadratic surface product
    nx[3]      = st[2];
    pq         = 66'(st[2].vfd) * 66'(st[2].sf);
    nx[3].psq  = pq[63:0];
    nx[3].lbh  = 64'(st[2].pubm[62:32]) * 64'(cfg.lin_b);
    nx[3].lbl  = 64'(st[2].pubm[31:0]) * 64'(cfg.lin_b);
    nx[3].qbh  = 64'(st[2].pubm[62:32]) * 64'(cfg.quad_b);
    nx[3].qbl  = 64'(st[2].pubm[31:0]) * 64'(cfg.quad_b);
    nx[3].pslm = fcmt_pkg::abs64(st[2].psl);
    nx[3].pslneg = st[2].psl[63];

    // stage 4
    nx[4]      = st[3];
    m          = fcmt_pkg::scale32(st[3].lbh, st[3].lbl);
    m2         = fcmt_pkg::scale32(st[3].qbh, st[3].qbl);
    nx[4].lb   = m.mag;
    nx[4].qb1  = m2.mag;
    nx[4].sat  = st[3].sat || m.sat || m2.sat;
    nx[4].slh  = 64'(st[3].pslm[62:32]) * 64'(cfg.lin_s);
    nx[4].sll  = 64'(st[3].pslm[31:0]) * 64'(cfg.lin_s);
    nx[4].psqm = fcmt_pkg::abs64(st[3].psq);
    nx[4].psqneg = st[3].psq[63];

    // stage 5
    nx[5]      = st[4];
    nx[5].m5h  = 64'(st[4].qb1[61:32]) * 64'(st[4].bspd);
    nx[5].m5l  = 64'(st[4].qb1[31:0]) * 64'(st[4].bspd);
    m          = fcmt_pkg::scale32(st[4].slh, st[4].sll);
    nx[5].sl   = m.mag;
    nx[5].sat  = st[4].sat || (m.sat && !st[4].mask);
    nx[5].sqh  = 64'(st[4].psqm[62:32]) * 64'(cfg.quad_s);
    nx[5].sql  = 64'(st[4].psqm[31:0]) * 64'(cfg.quad_s);

    // stage 6
    nx[6]      = st[5];
    m          = fcmt_pkg::scale16(st[5].m5h, st[5].m5l);
    m2         = fcmt_pkg::scale32(st[5].sqh, st[5].sql);
    nx[6].qb   = m.mag;
    nx[6].sq1  = m2.mag;
    nx[6].sat  = st[5].sat || m.sat || (m2.sat && !st[5].mask);

    // stage 7: surface speed products, start of the running sum
    nx[7]      = st[6];
    nx[7].sqmh = 64'(st[6].sq1[61:32]) * 64'(st[6].sspd);
    nx[7].sqml = 64'(st[6].sq1[31:0]) * 64'(st[6].sspd);
    a          = fcmt_pkg::add_clamp(st[6].w, fcmt_pkg::drag_delta(st[6].pubneg, st[6].lb));
    nx[7].acc  = a.val;
    nx[7].sat  = st[6].sat || a.sat;

    // stage 8
    nx[8]      = st[7];
    m          = fcmt_pkg::scale16(st[7].sqmh, st[7].sqml);
    nx[8].sq   = m.mag;
    a          = fcmt_pkg::add_clamp(st[7].acc, fcmt_pkg::drag_delta(st[7].pubneg, st[7].qb));
    nx[8].acc  = a.val;
    nx[8].sat  = st[7].sat || a.sat || (m.sat && !st[7].mask);

    // stage 9: surface terms drop out under the land mask
    nx[9]      = st[8];
    a          = fcmt_pkg::add_clamp(st[8].acc, st[8].mask ? '0 :
                   fcmt_pkg::drag_delta(st[8].pslneg, st[8].sl));
    nx[9].acc  = a.val;
    nx[9].sat  = st[8].sat || a.sat;

    // stage 10
    nx[10]     = st[9];
    a          = fcmt_pkg::add_clamp(st[9].acc, st[9].mask ? '0 :
                   fcmt_pkg::drag_delta(st[9].psqneg, st[9].sq));
    nx[10].acc = a.val;
    nx[10].sat = st[9].sat || a.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Stages; k++) begin
        st[k] <= nx[k];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/fcmt_back.sv
// back pipeline: divides the sum by the thickness, adds body force, saturates
`default_nettype none
module fcmt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               pop,
  input  fcmt_pkg::qent_t    q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] tendency_increment,
  output logic               saturated
);
  localparam int unsigned Div   = fcmt_pkg::DivSteps;
  localparam int unsigned Total = Div + 2;

  typedef struct packed {
    logic               hnz;
    logic               qneg;
    logic               ovf;
    logic               sat;
    logic [32:0]        rem;
    logic [32:0]        wq;
    logic [31:0]        hmag;
    logic signed [31:0] fb;
  } dv_t;

  dv_t st [Div+1];
  dv_t nx [Div+1];
  logic [Total-1:0] v;
  logic adv;
  logic signed [31:0] res_next;
  logic               sat_next;

  assign adv       = !v[Total-1] || out_ready;
  assign pop       = adv && !q_empty;
  assign out_valid = v[Total-1];

  always_comb begin
    logic [62:0]        amag;
    logic signed [31:0] nh;
    logic [32:0]        t;
    logic               ge;
    logic [32:0]        q;
    logic signed [34:0] sq;
    logic signed [35:0] sum;

    // setup: magnitudes, quotient sign and early overflow check
    amag          = fcmt_pkg::abs64(q_data.acc);
    nh            = -q_data.h;
    nx[0].hnz     = q_data.hnz;
    nx[0].qneg    = q_data.acc[63] ^ q_data.h[31];
    nx[0].hmag    = q_data.h[31] ? nh : q_data.h;
    // quotient of 2^33 or more saturates whatever the body force
    nx[0].ovf     = q_data.hnz && (32'(amag[61:33]) >= nx[0].hmag);
    nx[0].sat     = q_data.sat;
    nx[0].fb      = q_data.fb;
    nx[0].rem     = 33'(amag[61:33]);
    nx[0].wq      = amag[32:0];

    // one restoring step per stage
    for (int k = 1; k <= Div; k++) begin
      nx[k]     = st[k-1];
      t         = {st[k-1].rem[31:0], st[k-1].wq[32]};
      ge        = (t >= {1'b0, st[k-1].hmag});
      nx[k].rem = ge ? t - {1'b0, st[k-1].hmag} : t;
      nx[k].wq  = {st[k-1].wq[31:0], ge};
    end

    q        = (st[Div].hnz && !st[Div].ovf) ? st[Div].wq : '0;
    sq       = st[Div].qneg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum      = 36'(sq) + 36'(st[Div].fb);
    sat_next = st[Div].sat;
    res_next = 32'(sum);
    if (st[Div].ovf) begin
      sat_next = 1'b1;
      res_next = st[Div].qneg ? fcmt_pkg::Int32Min : fcmt_pkg::Int32Max;
    end else if (sum > fcmt_pkg::Int32MaxW) begin
      sat_next = 1'b1;
      res_next = fcmt_pkg::Int32Max;
    end else if (sum < fcmt_pkg::Int32MinW) begin
      sat_next = 1'b1;
      res_next = fcmt_pkg::Int32Min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[Total-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= Div; k++) begin
        st[k] <= nx[k];
      end
      tendency_increment <= res_next;
      saturated          <= sat_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/face_momentum_forcing_tendency.sv
// top level of the face momentum forcing block: registers, front, queue, back
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, face fields          | one face item per handshake
//  out     | out_valid, out_ready, tendency, saturated | one result item per input
//  cfg     | cfg_we, cfg_addr, cfg_data               | one register write per cycle
//
// one item per cycle sustained while out_ready stays high; the path runs through 11 term stages,
// the queue, one divider setup stage, 33 restoring divider stages, one output stage.
// the 33-stage divider (one quotient bit per stage) sets the latency.
// rst clears the config registers and all valid state; no clearing pass.
// a stalled output holds the back; the front keeps accepting until the queue fills.
`default_nettype none
module face_momentum_forcing_tendency #(
  parameter int unsigned QueueDepth = fcmt_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] face_velocity,
  input  logic signed [31:0] face_thickness,
  input  logic signed [31:0] surface_part,
  input  logic signed [31:0] bottom_part,
  input  logic signed [31:0] wind_stress,
  input  logic signed [31:0] lid_velocity,
  input  logic signed [31:0] body_force,
  input  logic [30:0]        bottom_speed_here,
  input  logic [30:0]        bottom_speed_behind,
  input  logic [30:0]        surface_speed_here,
  input  logic [30:0]        surface_speed_behind,
  input  logic               over_land,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] tendency_increment,
  output logic               saturated
);
  fcmt_pkg::cfg_t  cfg;
  fcmt_pkg::qent_t push_data;
  fcmt_pkg::qent_t pop_data;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (fcmt_pkg::cfg_reg_t'(cfg_addr))
        fcmt_pkg::RegModeFlags:       cfg.mode   <= cfg_data[4:0];
        fcmt_pkg::RegLinDragBottom:   cfg.lin_b  <= cfg_data;
        fcmt_pkg::RegQuadDragBottom:  cfg.quad_b <= cfg_data;
        fcmt_pkg::RegLinDragSurface:  cfg.lin_s  <= cfg_data;
        fcmt_pkg::RegQuadDragSurface: cfg.quad_s <= cfg_data;
        default: ;
      endcase
    end
  end

  fcmt_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .cfg                  (cfg),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .face_velocity        (face_velocity),
    .face_thickness       (face_thickness),
    .surface_part         (surface_part),
    .bottom_part          (bottom_part),
    .wind_stress          (wind_stress),
    .lid_velocity         (lid_velocity),
    .body_force           (body_force),
    .bottom_speed_here    (bottom_speed_here),
    .bottom_speed_behind  (bottom_speed_behind),
    .surface_speed_here   (surface_speed_here),
    .surface_speed_behind (surface_speed_behind),
    .over_land            (over_land),
    .push                 (push),
    .q_full               (q_full),
    .push_data            (push_data)
  );

  fcmt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fcmt_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (q_empty),
    .pop                (pop),
    .q_data             (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .tendency_increment (tendency_increment),
    .saturated          (saturated)
  );

endmodule
`default_nettype wire

FILE: dv/face_momentum_forcing_tendency_tb.sv
// testbench for the face momentum forcing tendency block
`default_nettype none
module face_momentum_forcing_tendency_tb;

  typedef struct {
    logic signed [31:0] u, h, sf, bp, tau, lid, fb;
    logic [30:0]        bsh, bsb, ssh, ssb;
    logic               land;
  } face_t;

  typedef struct {
    logic signed [31:0] tend;
    logic               sat;
  } tend_t;

  localparam longint TermMax = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] face_velocity = '0, face_thickness = '0, surface_part = '0;
  logic signed [31:0] bottom_part = '0, wind_stress = '0, lid_velocity = '0;
  logic signed [31:0] body_force = '0;
  logic [30:0] bottom_speed_here = '0, bottom_speed_behind = '0;
  logic [30:0] surface_speed_here = '0, surface_speed_behind = '0;
  logic over_land = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] tendency_increment;
  logic saturated;

  face_momentum_forcing_tendency dut (.*);

  // shadow registers of the block
  logic [4:0]  mode_q;
  logic [31:0] lin_b_q, quad_b_q, lin_s_q, quad_s_q;

  face_t pending_faces[$];
  tend_t expected_tend[$];
  int errors = 0;
  int cycles = 0;
  int hold_requests = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp_term(longint v, inout bit sat);
    if (v > TermMax) begin
      sat = 1'b1;
      return TermMax;
    end
    if (v < -TermMax) begin
      sat = 1'b1;
      return -TermMax;
    end
    return v;
  endfunction

  // truncating scale by a q0.32 coefficient or a q16.16 speed
  function automatic longint scale_by(longint p, logic [31:0] m, bit q16, inout bit sat);
    bit neg;
    logic [63:0] mag, hi, lo, r, a;
    neg = p < 0;
    mag = neg ? 64'(-p) : 64'(p);
    hi = mag >> 32;
    lo = {32'b0, mag[31:0]};
    if (!q16) begin
      r = hi * {32'b0, m} + ((lo * {32'b0, m}) >> 32);
    end else begin
      a = hi * {32'b0, m};
      if (a > (64'(TermMax) >> 16)) r = 64'(TermMax) + 1;
      else r = (a << 16) + ((lo * {32'b0, m}) >> 16);
    end
    if (r > 64'(TermMax)) begin
      sat = 1'b1;
      r = 64'(TermMax);
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic tend_t predict_tendency(face_t f);
    bit sat;
    longint u, lid, sf, bp, acc, t, vf, res;
    logic [31:0] bspd, sspd;
    bit mask;
    tend_t o;
    sat = 1'b0;
    u = f.u; lid = f.lid; sf = f.sf; bp = f.bp;
    bspd = 32'(({1'b0, f.bsh} + {1'b0, f.bsb}) >> 1);
    sspd = 32'(({1'b0, f.ssh} + {1'b0, f.ssb}) >> 1);
    mask = !mode_q[fcmt_pkg::ModeOceanDrag] && mode_q[fcmt_pkg::ModeRigidLid] && f.land;
    res = 0;
    if (f.h != 0) begin
      acc = 0;
      if (mode_q[fcmt_pkg::ModeWind]) begin
        t = clamp_term(longint'(f.tau) * sf, sat);
        acc = clamp_term(acc + t, sat);
      end
      t = scale_by(u * bp, lin_b_q, 1'b0, sat);
      acc = clamp_term(acc - t, sat);
      t = scale_by(u * bp, quad_b_q, 1'b0, sat);
      t = scale_by(t, bspd, 1'b1, sat);
      acc = clamp_term(acc - t, sat);
      if (!mask) begin
        vf = mode_q[fcmt_pkg::ModeFeedback] ? (u * 7) / 10 : u;
        t = scale_by((u - lid) * sf, lin_s_q, 1'b0, sat);
        acc = clamp_term(acc - t, sat);
        t = scale_by((vf - lid) * sf, quad_s_q, 1'b0, sat);
        t = scale_by(t, sspd, 1'b1, sat);
        acc = clamp_term(acc - t, sat);
      end
      res = acc / longint'(f.h);
    end
    if (mode_q[fcmt_pkg::ModeBody]) res += longint'(f.fb);
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      sat = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      sat = 1'b1;
    end
    o.tend = 32'(res);
    o.sat = sat;
    return o;
  endfunction

  // sender: bursts and gaps; prediction at acceptance
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    face_t f;
    if (rst) begin
      in_valid <= 1'b0;
      mode_q <= '0;
      lin_b_q <= '0; quad_b_q <= '0; lin_s_q <= '0; quad_s_q <= '0;
    end else begin
      if (in_valid && in_ready) begin
        f.u = face_velocity; f.h = face_thickness; f.sf = surface_part;
        f.bp = bottom_part; f.tau = wind_stress; f.lid = lid_velocity;
        f.fb = body_force; f.bsh = bottom_speed_here; f.bsb = bottom_speed_behind;
        f.ssh = surface_speed_here; f.ssb = surface_speed_behind; f.land = over_land;
        expected_tend.push_back(predict_tendency(f));
      end
      if (!in_valid || in_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_faces.size() > 0) begin
          f = pending_faces.pop_front();
          burst_left--;
          in_valid <= 1'b1;
          face_velocity <= f.u; face_thickness <= f.h; surface_part <= f.sf;
          bottom_part <= f.bp; wind_stress <= f.tau; lid_velocity <= f.lid;
          body_force <= f.fb; bottom_speed_here <= f.bsh; bottom_speed_behind <= f.bsb;
          surface_speed_here <= f.ssh; surface_speed_behind <= f.ssb; over_land <= f.land;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          fcmt_pkg::RegModeFlags:       mode_q <= cfg_data[4:0];
          fcmt_pkg::RegLinDragBottom:   lin_b_q <= cfg_data;
          fcmt_pkg::RegQuadDragBottom:  quad_b_q <= cfg_data;
          fcmt_pkg::RegLinDragSurface:  lin_s_q <= cfg_data;
          fcmt_pkg::RegQuadDragSurface: quad_s_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  logic [15:0] ready_pattern = 16'hFFFF;
  int hold_left = 0, holds_seen = 0, pattern_age = 0;
  always @(posedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = 300;
    end
    if (pattern_age == 64) begin
      pattern_age = 0;
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'hAAAA;
        default: ready_pattern = 16'($urandom);
      endcase
    end
    pattern_age++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // result checker
  always @(posedge clk) begin
    tend_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_tend.size() == 0) begin
        errors++;
        $display("%0t: unexpected item tendency=%h sat=%b", $time,
                 tendency_increment, saturated);
      end else begin
        e = expected_tend.pop_front();
        if (tendency_increment !== e.tend) begin
          errors++;
          $display("%0t: tendency expected %h actual %h", $time, e.tend,
                   tendency_increment);
        end
        if (saturated !== e.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("face_momentum_forcing_tendency verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word(bit is_speed);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'h0;
      3, 4, 5: v = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: v = $urandom;
    endcase
    return is_speed ? {1'b0, v[30:0]} : v;
  endfunction

  function automatic face_t random_face();
    face_t f;
    f.u = pick_word(0); f.sf = pick_word(0); f.bp = pick_word(0);
    f.tau = pick_word(0); f.lid = pick_word(0); f.fb = pick_word(0);
    case ($urandom_range(0, 7))
      0: f.h = '0;
      1: f.h = pick_word(0);
      2: f.h = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      default: f.h = 32'($urandom_range(1, 32'h0100_0000));
    endcase
    f.bsh = 31'(pick_word(1)); f.bsb = 31'(pick_word(1));
    f.ssh = 31'(pick_word(1)); f.ssb = 31'(pick_word(1));
    f.land = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 32'h0100_0000));
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(input fcmt_pkg::cfg_reg_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
  endtask

  task automatic cfg_all(input logic [4:0] mode, input logic [31:0] lb, input logic [31:0] qb,
                         input logic [31:0] ls, input logic [31:0] qs);
    cfg_write(fcmt_pkg::RegModeFlags, {27'($urandom), mode});
    cfg_write(fcmt_pkg::RegLinDragBottom, lb);
    cfg_write(fcmt_pkg::RegQuadDragBottom, qb);
    cfg_write(fcmt_pkg::RegLinDragSurface, ls);
    cfg_write(fcmt_pkg::RegQuadDragSurface, qs);
    // indexes past the last register must be ignored
    @(posedge clk);
    cfg_addr <= 3'(fcmt_pkg::RegQuadDragSurface) + 3'($urandom_range(1, 3));
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_faces.size() != 0 || in_valid || expected_tend.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    face_t f;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values, then extremes with the land mask active
    repeat (5) pending_faces.push_back(random_face());
    drain();
    cfg_all(5'b10111, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      f.u = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      f.sf = i[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
      f.bp = i[2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      f.tau = i[3] ? 32'h7FFF_FFFF : 32'h8000_0000;
      f.lid = ~f.u;
      f.fb = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      f.h = (i % 5 == 0) ? 32'sd0 : (i[1] ? 32'sd1 : -32'sd65536);
      f.bsh = i[2] ? '1 : '0; f.bsb = i[3] ? '1 : '0;
      f.ssh = i[0] ? '1 : '0; f.ssb = i[1] ? '1 : '0;
      f.land = i[2];
      pending_faces.push_back(f);
    end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) cfg_all(5'b00000, '0, '0, '0, '0);
      else if (ph == 1) cfg_all(5'b11111, '1, '1, '1, '1);
      else cfg_all(5'($urandom), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      if (ph == 3) hold_requests++;
      repeat (80) pending_faces.push_back(random_face());
      drain();
    end

    if (errors == 0) $display("face_momentum_forcing_tendency verification clean");
    else $display("face_momentum_forcing_tendency verification failed");
    $finish;
  end

endmodule
`default_nettype wire
